@@ hdl/mip_select_hough_rho_top_macros.svh @@
`ifndef MIP_SELECT_HOUGH_RHO_TOP_MACROS_SVH
`define MIP_SELECT_HOUGH_RHO_TOP_MACROS_SVH

// same-cycle implication, checked on clk and disabled while rst_n is low
`define MHR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk and disabled while rst_n is low
`define MHR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mhr_pkg.sv @@
package mhr_pkg;

  localparam int POS_W      = 20;
  localparam int LAYER_W    = 8;
  localparam int HITS_W     = 12;
  localparam int IDX_W      = 8;
  localparam int STEP_W     = 6;
  localparam int RHO_W      = 21;
  localparam int SIN_W      = 16;
  localparam int COS_W      = 17;
  localparam int PROD_W     = POS_W + COS_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int NB_LIM_W   = 9;

  localparam int NEAR_LIMIT = 800;
  localparam int CORE_HITS  = 5;
  localparam int RHO_MAX    = 1048575;
  localparam int RHO_MIN    = -1048576;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MAX_HITS = 2'd0;
  localparam cfg_idx_t CFG_MAX_NB   = 2'd1;
  localparam cfg_idx_t CFG_MAX_CORE = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [LAYER_W-1:0]      layer;
    logic [HITS_W-1:0]       hits;
  } cluster_t;

  // taylor series in q2.30, rounded to q1.15; evaluated at elaboration only
  function automatic logic [SIN_W-1:0] trig_q15(input logic [63:0] x, input logic is_sin);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        tmp;
    logic signed [63:0] acc;
    x2   = (x * x) >> 30;
    term = is_sin ? x : ONE_Q30;
    acc  = $signed(term);
    for (int k = 1; k < 8; k++) begin
      tmp = (term * x2) >> 30;
      case (k)
        1: term = is_sin ? tmp / 64'd6   : tmp / 64'd2;
        2: term = is_sin ? tmp / 64'd20  : tmp / 64'd12;
        3: term = is_sin ? tmp / 64'd42  : tmp / 64'd30;
        4: term = is_sin ? tmp / 64'd72  : tmp / 64'd56;
        5: term = is_sin ? tmp / 64'd110 : tmp / 64'd90;
        6: term = is_sin ? tmp / 64'd156 : tmp / 64'd132;
        7: term = is_sin ? tmp / 64'd210 : tmp / 64'd182;
        default: term = tmp;
      endcase
      if (k % 2 == 1) acc = acc - $signed(term);
      else            acc = acc + $signed(term);
    end
    if (acc < 0) acc = 0;
    if (acc > $signed(ONE_Q30)) acc = $signed(ONE_Q30);
    return SIN_W'((acc + 64'sd16384) >>> 15);
  endfunction

  // round, scale down by 2^15 and clamp to the rho range
  function automatic logic signed [RHO_W-1:0] rho_sat(input logic signed [PROD_W-1:0] a,
                                                      input logic signed [PROD_W-1:0] b);
    logic signed [PROD_W+1:0] sum;
    logic signed [PROD_W-14:0] q;
    sum = (PROD_W+2)'(a) + (PROD_W+2)'(b) + (PROD_W+2)'(16384);
    q   = sum[PROD_W+1:15];
    if (q > RHO_MAX)      return RHO_W'(RHO_MAX);
    else if (q < RHO_MIN) return RHO_W'(RHO_MIN);
    else                  return q[RHO_W-1:0];
  endfunction

endpackage

@@ hdl/mhr_if.sv @@
interface mhr_in_if;
  import mhr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic                    restart;
  logic [IDX_W-1:0]        cluster_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [LAYER_W-1:0]      layer;
  logic [HITS_W-1:0]       hit_count;
  modport source(output valid, mode, restart, cluster_index, pos_x, pos_y, pos_z, layer,
                 hit_count, input ready);
  modport sink(input valid, mode, restart, cluster_index, pos_x, pos_y, pos_z, layer,
               hit_count, output ready);
endinterface

interface mhr_out_if;
  import mhr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_index;
  logic                    candidate;
  logic [STEP_W-1:0]       theta_step;
  logic signed [RHO_W-1:0] rho_x;
  logic signed [RHO_W-1:0] rho_y;
  logic                    last;
  modport source(output valid, out_index, candidate, theta_step, rho_x, rho_y, last,
                 input ready);
  modport sink(input valid, out_index, candidate, theta_step, rho_x, rho_y, last,
               output ready);
endinterface

interface mhr_cfg_if;
  import mhr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/mhr_ram.sv @@
module mhr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/mhr_mul.sv @@
module mhr_mul (
  input  logic                              clk,
  input  logic signed [mhr_pkg::POS_W-1:0]  a,
  input  logic signed [mhr_pkg::COS_W-1:0]  b,
  output logic signed [mhr_pkg::PROD_W-1:0] p
);
  import mhr_pkg::*;

  // registered signed product, shared by all three rho terms
  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

@@ hdl/mhr_trig_rom.sv @@
module mhr_trig_rom #(
  parameter int THETA_STEPS = 64
) (
  input  logic                             clk,
  input  logic [$clog2(THETA_STEPS)-1:0]   step,
  output logic [mhr_pkg::SIN_W-1:0]        sin_q,
  output logic signed [mhr_pkg::COS_W-1:0] cos_q
);
  import mhr_pkg::*;

  logic [SIN_W-1:0]        sin_tab [THETA_STEPS];
  logic signed [COS_W-1:0] cos_tab [THETA_STEPS];

  // angle folded into the first quadrant, cosine negated past pi/2
  for (genvar g = 0; g < THETA_STEPS; g++) begin : g_tab
    localparam int          SRED = (2 * g > THETA_STEPS) ? THETA_STEPS - g : g;
    localparam logic [63:0] ANG  = (64'(SRED) * PI_Q30) / THETA_STEPS;
    localparam logic [SIN_W-1:0] SQ = trig_q15(ANG, 1'b1);
    localparam logic [SIN_W-1:0] CQ = trig_q15(ANG, 1'b0);
    assign sin_tab[g] = SQ;
    assign cos_tab[g] = (2 * g > THETA_STEPS) ? -$signed({1'b0, CQ}) : $signed({1'b0, CQ});
  end

  always_ff @(posedge clk) begin
    sin_q <= sin_tab[step];
    cos_q <= cos_tab[step];
  end

endmodule

@@ hdl/mip_select_hough_rho_top.sv @@
// load transaction: the block stays in idle, so the next one can follow in the next cycle
// evaluate transaction: the target read, then a scan of the store through its
//   single read port, then per theta step the rom, z*cos, x*sin, y*sin and emit
//   states on the shared multiplier (3 products per step); emit waits while the output is held
// reject or unknown index: one result with candidate low and last set, and no theta steps
// reset: control, fill count and limits cleared to defaults, store contents undefined
`include "mip_select_hough_rho_top_macros.svh"

module mip_select_hough_rho_top #(
  parameter int MAX_CLUSTERS = 256,
  parameter int THETA_STEPS  = 64
) (
  input logic         clk,
  input logic         rst_n,
  mhr_in_if.sink      in_if,
  mhr_out_if.source   out_if,
  mhr_cfg_if.sink     cfg_if
);
  import mhr_pkg::*;

  localparam int AW   = $clog2(MAX_CLUSTERS);
  localparam int LC_W = $clog2(MAX_CLUSTERS + 1);
  localparam int CW   = (LC_W > NB_LIM_W) ? LC_W : NB_LIM_W;
  localparam int SW   = $clog2(THETA_STEPS);

  // sequencer states
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_TGT    = 9'b000000010,
    S_SCAN   = 9'b000000100,
    S_REJECT = 9'b000001000,
    S_ROM    = 9'b000010000,
    S_MZC    = 9'b000100000,
    S_MXS    = 9'b001000000,
    S_MYS    = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // control
  logic [LC_W-1:0]     loaded_r, loaded_nxt;
  logic [HITS_W-1:0]   max_hits_r, max_hits_nxt;
  logic [NB_LIM_W-1:0] max_nb_r, max_nb_nxt;
  logic [NB_LIM_W-1:0] max_core_r, max_core_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic                out_valid_r, out_valid_nxt;

  // working payload
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  cluster_t                 tgt_r, tgt_nxt;
  logic [LC_W-1:0]          scan_r, scan_nxt;
  logic [LC_W-1:0]          chk_r, chk_nxt;
  logic [LC_W-1:0]          nb_r, nb_nxt;
  logic [LC_W-1:0]          core_r, core_nxt;
  logic [SW-1:0]            step_r, step_nxt;
  logic signed [PROD_W-1:0] zc_r, zc_nxt;
  logic signed [RHO_W-1:0]  rhox_r, rhox_nxt;

  // output register
  logic [IDX_W-1:0]        out_idx_r, out_idx_nxt;
  logic                    out_cand_r, out_cand_nxt;
  logic [STEP_W-1:0]       out_step_r, out_step_nxt;
  logic signed [RHO_W-1:0] out_rhox_r, out_rhox_nxt;
  logic signed [RHO_W-1:0] out_rhoy_r, out_rhoy_nxt;
  logic                    out_last_r, out_last_nxt;

  // store, multiplier and trig table hookup
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  cluster_t                 ram_wdata;
  logic [AW-1:0]            ram_raddr;
  cluster_t                 rd_c;
  logic signed [POS_W-1:0]  mul_a;
  logic signed [COS_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [SIN_W-1:0]         sin_q;
  logic signed [COS_W-1:0]  cos_q;

  logic                in_accept;
  logic                out_free;
  logic [LC_W-1:0]     load_base;
  logic                load_room;
  logic                idx_ok;
  logic signed [POS_W:0] dx;
  logic signed [POS_W:0] dy;
  logic                is_nb;
  logic                is_core;
  logic                is_cand;
  logic                step_last;

  assign in_accept = in_if.valid && in_if.ready;
  assign out_free  = !out_valid_r || out_if.ready;

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid      = out_valid_r;
  assign out_if.out_index  = out_idx_r;
  assign out_if.candidate  = out_cand_r;
  assign out_if.theta_step = out_step_r;
  assign out_if.rho_x      = out_rhox_r;
  assign out_if.rho_y      = out_rhoy_r;
  assign out_if.last       = out_last_r;

  // a restart appends at slot zero; a full store drops the load
  assign load_base = in_if.restart ? '0 : loaded_r;
  assign load_room = load_base < LC_W'(MAX_CLUSTERS);
  assign idx_ok    = CW'(in_if.cluster_index) < CW'(loaded_r);

  assign ram_we    = in_accept && !in_if.mode && load_room;
  assign ram_waddr = load_base[AW-1:0];

  always_comb begin
    ram_wdata.pos_x = in_if.pos_x;
    ram_wdata.pos_y = in_if.pos_y;
    ram_wdata.pos_z = in_if.pos_z;
    ram_wdata.layer = in_if.layer;
    ram_wdata.hits  = in_if.hit_count;
  end

  // read port: target entry on accept, then entry 0 onward
  always_comb begin
    case (state_r)
      S_IDLE:  ram_raddr = AW'(in_if.cluster_index);
      S_TGT:   ram_raddr = '0;
      default: ram_raddr = scan_r[AW-1:0];
    endcase
  end

  mhr_ram #(
    .WIDTH ($bits(cluster_t)),
    .DEPTH (MAX_CLUSTERS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_c)
  );

  // neighbour test on the entry read last cycle
  assign dx      = (POS_W+1)'(tgt_r.pos_x) - (POS_W+1)'(rd_c.pos_x);
  assign dy      = (POS_W+1)'(tgt_r.pos_y) - (POS_W+1)'(rd_c.pos_y);
  assign is_nb   = chk_vld_r && (CW'(chk_r) != CW'(idx_r)) && (rd_c.layer == tgt_r.layer)
                   && (dx < NEAR_LIMIT) && (dx > -NEAR_LIMIT)
                   && (dy < NEAR_LIMIT) && (dy > -NEAR_LIMIT);
  assign is_core = rd_c.hits > HITS_W'(CORE_HITS);
  assign is_cand = (CW'(nb_r) <= CW'(max_nb_r)) || (CW'(core_r) <= CW'(max_core_r));

  assign step_last = (step_r == SW'(THETA_STEPS - 1));

  // multiplier operand select: z*cos, then x*sin, then y*sin held until emitted
  always_comb begin
    case (state_r)
      S_MZC: begin
        mul_a = tgt_r.pos_z;
        mul_b = cos_q;
      end
      S_MXS: begin
        mul_a = tgt_r.pos_x;
        mul_b = $signed({1'b0, sin_q});
      end
      default: begin
        mul_a = tgt_r.pos_y;
        mul_b = $signed({1'b0, sin_q});
      end
    endcase
  end

  mhr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  mhr_trig_rom #(
    .THETA_STEPS (THETA_STEPS)
  ) u_trig (
    .clk   (clk),
    .step  (step_r),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    max_hits_nxt  = max_hits_r;
    max_nb_nxt    = max_nb_r;
    max_core_nxt  = max_core_r;
    chk_vld_nxt   = chk_vld_r;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    tgt_nxt       = tgt_r;
    scan_nxt      = scan_r;
    chk_nxt       = chk_r;
    nb_nxt        = nb_r;
    core_nxt      = core_r;
    step_nxt      = step_r;
    zc_nxt        = zc_r;
    rhox_nxt      = rhox_r;
    out_idx_nxt   = out_idx_r;
    out_cand_nxt  = out_cand_r;
    out_step_nxt  = out_step_r;
    out_rhox_nxt  = out_rhox_r;
    out_rhoy_nxt  = out_rhoy_r;
    out_last_nxt  = out_last_r;

    // limit registers
    if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_MAX_HITS: max_hits_nxt = cfg_if.data[HITS_W-1:0];
        CFG_MAX_NB:   max_nb_nxt   = cfg_if.data[NB_LIM_W-1:0];
        CFG_MAX_CORE: max_core_nxt = cfg_if.data[NB_LIM_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (!in_if.mode) begin
            loaded_nxt = load_room ? load_base + LC_W'(1) : load_base;
          end else begin
            idx_nxt   = in_if.cluster_index;
            state_nxt = idx_ok ? S_TGT : S_REJECT;
          end
        end
      end
      S_TGT: begin
        // target entry is on the read port now
        tgt_nxt  = rd_c;
        nb_nxt   = '0;
        core_nxt = '0;
        if (rd_c.hits > max_hits_r) begin
          state_nxt = S_REJECT;
        end else begin
          chk_nxt     = '0;
          chk_vld_nxt = 1'b1;
          scan_nxt    = LC_W'(1);
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chk_vld_r) begin
          if (is_nb) begin
            nb_nxt = nb_r + LC_W'(1);
            if (is_core) begin
              core_nxt = core_r + LC_W'(1);
            end
          end
          chk_nxt     = scan_r;
          chk_vld_nxt = scan_r < loaded_r;
          if (scan_r < loaded_r) begin
            scan_nxt = scan_r + LC_W'(1);
          end
        end else begin
          step_nxt  = '0;
          state_nxt = is_cand ? S_ROM : S_REJECT;
        end
      end
      S_REJECT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_r;
          out_cand_nxt  = 1'b0;
          out_step_nxt  = '0;
          out_rhox_nxt  = '0;
          out_rhoy_nxt  = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ROM: begin
        state_nxt = S_MZC;
      end
      S_MZC: begin
        state_nxt = S_MXS;
      end
      S_MXS: begin
        zc_nxt    = prod;
        state_nxt = S_MYS;
      end
      S_MYS: begin
        rhox_nxt  = rho_sat(zc_r, prod);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_r;
          out_cand_nxt  = 1'b1;
          out_step_nxt  = STEP_W'(step_r);
          out_rhox_nxt  = rhox_r;
          out_rhoy_nxt  = rho_sat(zc_r, prod);
          out_last_nxt  = step_last;
          if (step_last) begin
            state_nxt = S_IDLE;
          end else begin
            step_nxt  = step_r + SW'(1);
            state_nxt = S_ROM;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      max_hits_r  <= HITS_W'(2);
      max_nb_r    <= NB_LIM_W'(2);
      max_core_r  <= NB_LIM_W'(1);
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      max_hits_r  <= max_hits_nxt;
      max_nb_r    <= max_nb_nxt;
      max_core_r  <= max_core_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    tgt_r      <= tgt_nxt;
    scan_r     <= scan_nxt;
    chk_r      <= chk_nxt;
    nb_r       <= nb_nxt;
    core_r     <= core_nxt;
    step_r     <= step_nxt;
    zc_r       <= zc_nxt;
    rhox_r     <= rhox_nxt;
    out_idx_r  <= out_idx_nxt;
    out_cand_r <= out_cand_nxt;
    out_step_r <= out_step_nxt;
    out_rhox_r <= out_rhox_nxt;
    out_rhoy_r <= out_rhoy_nxt;
    out_last_r <= out_last_nxt;
  end

  // fill count never passes the store depth
  `MHR_ASSERT_SAME(a_fill_bound, 1'b1, loaded_r <= LC_W'(MAX_CLUSTERS), "fill count overflow")
  // a rejection is always a single, final transaction
  `MHR_ASSERT_SAME(a_reject_last, out_valid_r && !out_cand_r, out_last_r, "reject without last")
  // the scan only checks entries that were loaded
  `MHR_ASSERT_SAME(a_scan_range, state_r == S_SCAN && chk_vld_r, chk_r < loaded_r,
                   "scan past fill count")
  // the final theta step hands the block back to idle
  `MHR_ASSERT_NEXT(a_last_idle, state_r == S_EMIT && out_free && step_last,
                   state_r == S_IDLE, "sequencer did not return to idle")

endmodule
